[rtl/b64c_pkg.sv]
// Shared types and constants for the base64 stream codec.
// No dependencies; every other file of the block imports this package.
package b64c_pkg;

    // Direction register codes.
    localparam logic DirEncode = 1'b0;
    localparam logic DirDecode = 1'b1;

    // Padding character '='.
    localparam logic [7:0] CharPad = 8'd61;

    // Most results that one request can cause.
    localparam int unsigned MaxResults = 4;

    // Queue depth between the classifier and the result sequencer.
    localparam int unsigned QueueDepth = 2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       msg_last;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_data;
        logic       run_last;
        logic       msg_end;
    } result_t;

    // Work for the result sequencer: the results one request causes.
    typedef struct packed {
        logic [MaxResults-1:0][7:0] bytes;
        logic [2:0]                 count;
        logic                       has_data;
        logic                       msg_end;
    } job_t;

endpackage

[rtl/b64c_front.sv]
// Front end of the base64 stream codec: takes requests, keeps the group state
// and turns each request into a job of up to four results. Uses b64c_pkg.
module b64c_front
    import b64c_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cfg_valid,
    output logic  cfg_ready,
    input  logic  cfg_data,
    input  logic  item_valid,
    output logic  item_ready,
    input  item_t item,
    output logic  push_valid,
    input  logic  push_ready,
    output job_t  push_job
);

    function automatic logic [7:0] sextet_char(input logic [5:0] s);
        logic [7:0] r;
        if (s < 6'd26) begin
            r = 8'd65 + {2'b00, s};
        end else if (s < 6'd52) begin
            r = 8'd71 + {2'b00, s};
        end else if (s < 6'd62) begin
            r = {2'b00, s} - 8'd4;
        end else if (s == 6'd62) begin
            r = 8'd43;
        end else begin
            r = 8'd47;
        end
        return r;
    endfunction

    // Bit 6 set means the character is outside the alphabet.
    function automatic logic [6:0] char_sextet(input logic [7:0] c);
        logic [6:0] r;
        if (c >= 8'd65 && c <= 8'd90) begin
            r = 7'(c - 8'd65);
        end else if (c >= 8'd97 && c <= 8'd122) begin
            r = 7'(c - 8'd71);
        end else if (c >= 8'd48 && c <= 8'd57) begin
            r = 7'(c + 8'd4);
        end else if (c == 8'd43) begin
            r = 7'd62;
        end else if (c == 8'd47) begin
            r = 7'd63;
        end else begin
            r = 7'h40;
        end
        return r;
    endfunction

    logic        direction_reg;
    logic [23:0] group_bits_reg;
    logic [23:0] group_bits_next;
    logic [1:0]  group_count_reg;
    logic [1:0]  group_count_next;
    logic        stopped_reg;
    logic        stopped_next;

    logic [23:0] enc_bits;
    logic [23:0] dec_bits;
    logic [2:0]  count_inc;
    logic [6:0]  sx;
    logic        bad;
    logic [23:0] pad_bits;
    logic [23:0] flush_bits;
    logic [1:0]  flush_count;
    logic [23:0] flush_v;
    logic [2:0]  n;
    job_t        job;
    logic        take;

    assign cfg_ready  = 1'b1;
    assign item_ready = push_ready;
    assign take       = item_valid && item_ready;
    assign push_valid = item_valid && (n != 3'd0);
    assign push_job   = job;

    always_comb
    begin
        job              = '0;
        job.has_data     = 1'b1;
        n                = 3'd0;
        group_bits_next  = group_bits_reg;
        group_count_next = group_count_reg;
        stopped_next     = stopped_reg;
        enc_bits         = {group_bits_reg[15:0], item.in_byte};
        count_inc        = {1'b0, group_count_reg} + 3'd1;
        sx               = char_sextet(item.in_byte);
        bad              = !stopped_reg && (item.in_byte == CharPad || sx[6]);
        dec_bits         = {group_bits_reg[17:0], sx[5:0]};
        pad_bits         = '0;
        flush_bits       = '0;
        flush_count      = '0;
        flush_v          = '0;

        if (direction_reg == DirEncode) begin
            if (count_inc == 3'd3) begin
                job.bytes[0]     = sextet_char(enc_bits[23:18]);
                job.bytes[1]     = sextet_char(enc_bits[17:12]);
                job.bytes[2]     = sextet_char(enc_bits[11:6]);
                job.bytes[3]     = sextet_char(enc_bits[5:0]);
                n                = 3'd4;
                group_bits_next  = '0;
                group_count_next = '0;
            end else begin
                group_bits_next  = enc_bits;
                group_count_next = count_inc[1:0];
                if (item.msg_last) begin
                    // A count of four (left by a decode group of three) pads
                    // out as an all-zero group with one character.
                    case (count_inc)
                        3'd1:    pad_bits = {enc_bits[7:0], 16'h0000};
                        3'd2:    pad_bits = {enc_bits[15:0], 8'h00};
                        default: pad_bits = '0;
                    endcase
                    job.bytes[0] = sextet_char(pad_bits[23:18]);
                    job.bytes[1] = (count_inc[1:0] >= 2'd1) ?
                                   sextet_char(pad_bits[17:12]) : CharPad;
                    job.bytes[2] = (count_inc[1:0] >= 2'd2) ?
                                   sextet_char(pad_bits[11:6]) : CharPad;
                    job.bytes[3] = CharPad;
                    n            = 3'd4;
                end
            end
        end else begin
            if (!stopped_reg) begin
                if (bad) begin
                    stopped_next     = 1'b1;
                    group_bits_next  = '0;
                    group_count_next = '0;
                end else if (count_inc == 3'd4) begin
                    job.bytes[0]     = dec_bits[23:16];
                    job.bytes[1]     = dec_bits[15:8];
                    job.bytes[2]     = dec_bits[7:0];
                    n                = 3'd3;
                    group_bits_next  = '0;
                    group_count_next = '0;
                end else begin
                    group_bits_next  = dec_bits;
                    group_count_next = count_inc[1:0];
                end
            end
            // A stop flushes the group held before this character; the end of
            // a message flushes the group held after it.
            flush_bits  = bad ? group_bits_reg : group_bits_next;
            flush_count = bad ? group_count_reg : group_count_next;
            if (bad || item.msg_last) begin
                case (flush_count)
                    2'd2:
                    begin
                        flush_v      = {flush_bits[11:0], 12'h000};
                        job.bytes[0] = flush_v[23:16];
                        n            = 3'd1;
                    end
                    2'd3:
                    begin
                        flush_v      = {flush_bits[17:0], 6'h00};
                        job.bytes[0] = flush_v[23:16];
                        job.bytes[1] = flush_v[15:8];
                        n            = 3'd2;
                    end
                    default: flush_v = '0;
                endcase
            end
        end

        if (item.msg_last) begin
            group_bits_next  = '0;
            group_count_next = '0;
            stopped_next     = 1'b0;
            if (n == 3'd0) begin
                n            = 3'd1;
                job.has_data = 1'b0;
            end
        end
        job.count   = n;
        job.msg_end = item.msg_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            direction_reg   <= DirEncode;
            group_bits_reg  <= '0;
            group_count_reg <= '0;
            stopped_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                direction_reg <= cfg_data;
            end
            if (take) begin
                group_bits_reg  <= group_bits_next;
                group_count_reg <= group_count_next;
                stopped_reg     <= stopped_next;
            end
        end
    end

endmodule

[rtl/b64c_queue.sv]
// Two-entry job queue between the front end and the result sequencer.
// Uses job_t and QueueDepth from b64c_pkg.
module b64c_queue
    import b64c_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    localparam int unsigned PtrW = $clog2(QueueDepth);
    localparam int unsigned CntW = $clog2(QueueDepth + 1);

    job_t            entries_reg [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CntW'(QueueDepth));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/b64c_back.sv]
// Result sequencer: walks each queued job into the output register, one
// result per cycle unless stalled. Uses job_t, result_t from b64c_pkg.
module b64c_back
    import b64c_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pop_valid,
    output logic    pop_ready,
    input  job_t    pop_job,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    logic       load;
    logic       is_last;

    assign load         = pop_valid && (!out_valid_reg || result_ready);
    assign is_last      = ({1'b0, idx_reg} == pop_job.count - 3'd1);
    assign pop_ready    = load && is_last;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_reg.out_byte <= pop_job.bytes[idx_reg];
            out_reg.has_data <= pop_job.has_data;
            out_reg.run_last <= is_last;
            out_reg.msg_end  <= pop_job.msg_end && is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                out_valid_reg <= 1'b1;
                idx_reg       <= is_last ? 2'd0 : idx_reg + 2'd1;
            end else if (result_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid |-> ({1'b0, idx_reg} < pop_job.count))
        else $error("result index runs past the job");

    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.msg_end) |-> result.run_last)
        else $error("message end without run end");

    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.has_data) |->
            (result.out_byte == 8'd0 && result.msg_end))
        else $error("malformed end marker");

    a_idx_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        pop_ready |=> (idx_reg == 2'd0))
        else $error("result index not reset after job");
`endif

endmodule

[rtl/base64_stream_codec_core.sv]
// Base64 stream codec: one request in, up to four result requests out.
// The first result of a request is registered in the job queue and then in
// the output register. Throughput: one request per cycle while the two-entry
// job queue has room; results leave at one per cycle from the output register
// while the consumer takes them. Reset clears direction to encode, the held
// group, the stop flag, the job queue and the output register.
module base64_stream_codec_core
    import b64c_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cfg_valid,
    output logic    cfg_ready,
    input  logic    cfg_data,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    // The front end classifies each request against the direction register
    // and the held group, updates that state in the same cycle, and writes a
    // job holding every result the request causes. Requests that cause
    // nothing write no job.
    logic push_valid;
    logic push_ready;
    job_t push_job;

    // The queue lets the front end keep taking requests while the sequencer
    // is still stepping through the four characters of an encoded group or
    // waiting on a stalled consumer.
    logic pop_valid;
    logic pop_ready;
    job_t pop_job;

    b64c_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    b64c_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // Emits one result per cycle unless stalled, and marks the last result of
    // each job with run_last, and the last of a message with msg_end.
    b64c_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_job      (pop_job),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

[dv/tb_base64_stream_codec_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench for base64_stream_codec_core: a directed table, then random messages
// in both directions, each result checked against the table or an in-bench codec model.
// Depends on b64c_pkg and the base64_stream_codec_core RTL; needs nothing else.
module tb_base64_stream_codec_core;
    import b64c_pkg::*;

    localparam int unsigned RandomItems = 350;
    // Cycles to let pass after the last expected result before a register write or the end.
    localparam int unsigned SettlePause = 8;
    localparam int unsigned CycleLimit  = 400000;
    localparam int unsigned ReportLimit = 10;
    // Marks a character outside the base64 alphabet.
    localparam logic [6:0]  NotAlphabet = 7'd64;

    // One row of the directed table. When n_typed is nonzero the results are typed in as text,
    // first character in the highest byte; end_marker asks for the single empty end marker.
    // Rows with neither are checked against the codec model.
    typedef struct packed {
        logic        dir;
        logic [7:0]  in_byte;
        logic        msg_last;
        logic [2:0]  n_typed;
        logic [31:0] typed_text;
        logic        end_marker;
    } vector_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    logic    cfg_data = DirEncode;
    logic    item_valid = 1'b0;
    logic    item_ready;
    item_t   item = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    // Codec model state, a private copy of what the block holds.
    logic        model_dir;
    logic [23:0] model_group;
    int          model_count;
    logic        model_halt;

    // Results of the request just taken, and every result still owed by the block.
    result_t step_results[$];
    result_t pending_results[$];
    vector_t directed[$];

    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned rx_stall = 0;
    bit          rx_calm = 1'b0;
    bit          tx_calm = 1'b0;

    base64_stream_codec_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Map a sextet to its character of the standard alphabet.
    function automatic logic [7:0] sextet_char(input logic [5:0] s);
        if (s < 26)
            return 8'("A" + s);
        if (s < 52)
            return 8'("a" + s - 26);
        if (s < 62)
            return 8'("0" + s - 52);
        return (s == 62) ? "+" : "/";
    endfunction

    // Map a character back to its sextet; anything outside the alphabet gives NotAlphabet.
    function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return 7'(c - "A");
        if (c >= "a" && c <= "z")
            return 7'(c - "a" + 26);
        if (c >= "0" && c <= "9")
            return 7'(c - "0" + 52);
        if (c == "+")
            return 7'd62;
        if (c == "/")
            return 7'd63;
        return NotAlphabet;
    endfunction

    function automatic void push_out(input logic [7:0] b, input logic has);
        result_t r;
        r.out_byte = has ? b : 8'h00;
        r.has_data = has;
        r.run_last = 1'b0;
        r.msg_end  = 1'b0;
        step_results.push_back(r);
    endfunction

    // A held decode group of i sextets leaves as i-1 bytes, the missing sextets read as zero.
    function automatic void flush_decode();
        int          held;
        logic [23:0] aligned;
        held = model_count & 3;
        if (held >= 2)
        begin
            aligned = model_group << (6 * (4 - held));
            for (int j = 0; j + 1 < held; j++)
                push_out(8'(aligned >> (16 - 8 * j)), 1'b1);
        end
        model_group = '0;
        model_count = 0;
    endfunction

    // Work out the results that one accepted request causes and advance the model state.
    function automatic void predict_codec(input item_t it);
        logic [6:0]  sx;
        logic [23:0] padded;
        int          held;
        result_t     tail;
        step_results.delete();
        if (model_dir == DirEncode)
        begin
            model_group = {model_group[15:0], it.in_byte};
            model_count = (model_count & 3) + 1;
            if (model_count == 3)
            begin
                for (int j = 0; j < 4; j++)
                    push_out(sextet_char(6'(model_group >> (18 - 6 * j))), 1'b1);
                model_group = '0;
                model_count = 0;
            end
            // A count of four is possible after a switch from decode; it reads as an empty group.
            if (it.msg_last && model_count != 0)
            begin
                held = model_count & 3;
                padded = model_group << (8 * (3 - held));
                for (int j = 0; j < 4; j++)
                    push_out((j <= held) ? sextet_char(6'(padded >> (18 - 6 * j))) : CharPad,
                             1'b1);
            end
        end
        else
        begin
            if (!model_halt)
            begin
                sx = (it.in_byte == CharPad) ? NotAlphabet : char_to_sextet(it.in_byte);
                if (sx == NotAlphabet)
                begin
                    model_halt = 1'b1;
                    flush_decode();
                end
                else
                begin
                    model_group = {model_group[17:0], sx[5:0]};
                    model_count = (model_count & 3) + 1;
                    if (model_count == 4)
                    begin
                        for (int j = 0; j < 3; j++)
                            push_out(8'(model_group >> (16 - 8 * j)), 1'b1);
                        model_group = '0;
                        model_count = 0;
                    end
                end
            end
            if (it.msg_last)
                flush_decode();
        end
        if (it.msg_last)
        begin
            if (step_results.size() == 0)
                push_out(8'h00, 1'b0);
            tail = step_results.pop_back();
            tail.msg_end = 1'b1;
            step_results.push_back(tail);
            model_group = '0;
            model_count = 0;
            model_halt = 1'b0;
        end
        if (step_results.size() != 0)
        begin
            tail = step_results.pop_back();
            tail.run_last = 1'b1;
            step_results.push_back(tail);
        end
    endfunction

    function automatic void queue_predicted();
        foreach (step_results[k])
            pending_results.push_back(step_results[k]);
    endfunction

    function automatic vector_t vec(input logic dir, input logic [7:0] b, input logic last,
                                    input logic [2:0] n, input logic [31:0] text,
                                    input logic marker);
        vector_t v;
        v.dir        = dir;
        v.in_byte    = b;
        v.msg_last   = last;
        v.n_typed    = n;
        v.typed_text = text;
        v.end_marker = marker;
        return v;
    endfunction

    function automatic void report_miss(input string what, input result_t want,
                                        input result_t got);
        mismatches++;
        if (mismatches <= ReportLimit)
        begin
            $display("%0t: %s: expected byte %02h data %0b run_last %0b msg_end %0b",
                     $time, what, want.out_byte, want.has_data, want.run_last, want.msg_end);
            $display("%0t: %s: got byte %02h data %0b run_last %0b msg_end %0b",
                     $time, what, got.out_byte, got.has_data, got.run_last, got.msg_end);
        end
    endfunction

    // Every result request must match the oldest result still owed, field by field.
    function automatic void check_result(input result_t got);
        result_t want;
        if (pending_results.size() == 0)
        begin
            report_miss("unexpected result", '0, got);
            return;
        end
        want = pending_results.pop_front();
        if (got.out_byte !== want.out_byte || got.has_data !== want.has_data ||
            got.run_last !== want.run_last || got.msg_end !== want.msg_end)
            report_miss("result mismatch", want, got);
    endfunction

    // Present one request after a random gap and hold it until the block takes it. The valid
    // is only lowered when a gap follows, so back-to-back requests never see a dip.
    task automatic send_request(input item_t it);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        predict_codec(it);
    endtask

    // Hold off the sender until the block owes nothing, then give it time to finish requests
    // that cause no result at all.
    task automatic settle();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SettlePause) @(posedge clk);
    endtask

    // The direction register is only written while the block is idle. The held group is
    // left alone, so a write in the middle of a message is legal and gets exercised.
    task automatic write_direction(input logic d);
        settle();
        cfg_data <= d;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        model_dir = d;
    endtask

    // Result side: after each result request the receiver stalls for a random number of
    // cycles, with calm stretches in which it never stalls.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                check_result(result);
                if ($urandom_range(0, 19) == 0)
                    rx_calm = !rx_calm;
                rx_stall = rx_calm ? 0 : $urandom_range(0, 15);
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
            end
            result_ready <= (rx_stall == 0);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        item_t       it;
        vector_t     v;
        result_t     r;
        int unsigned sent;
        int unsigned msg_len;
        int unsigned n_pad;
        bit          noisy;
        logic [7:0]  b;

        model_dir   = DirEncode;
        model_group = '0;
        model_count = 0;
        model_halt  = 1'b0;

        // Encode: one byte pads with two '=', all-ones and a known word give full groups,
        // and a two-byte message pads with one '='.
        directed.push_back(vec(DirEncode, 8'h00, 1'b1, 3'd4, "AA==", 1'b0));
        directed.push_back(vec(DirEncode, 8'hff, 1'b0, 3'd0, 32'h0, 1'b0));
        directed.push_back(vec(DirEncode, 8'hff, 1'b0, 3'd0, 32'h0, 1'b0));
        directed.push_back(vec(DirEncode, 8'hff, 1'b1, 3'd4, "////", 1'b0));
        directed.push_back(vec(DirEncode, 8'hff, 1'b0, 3'd0, 32'h0, 1'b0));
        directed.push_back(vec(DirEncode, 8'h00, 1'b1, 3'd0, 32'h0, 1'b0));
        directed.push_back(vec(DirEncode, "M", 1'b0, 3'd0, 32'h0, 1'b0));
        directed.push_back(vec(DirEncode, "a", 1'b0, 3'd0, 32'h0, 1'b0));
        directed.push_back(vec(DirEncode, "n", 1'b1, 3'd4, "TWFu", 1'b0));
        // Decode: a full group, then padding on the final item leaves only the end marker.
        directed.push_back(vec(DirDecode, "T", 1'b0, 3'd0, 32'h0, 1'b0));
        directed.push_back(vec(DirDecode, "W", 1'b0, 3'd0, 32'h0, 1'b0));
        directed.push_back(vec(DirDecode, "F", 1'b0, 3'd0, 32'h0, 1'b0));
        directed.push_back(vec(DirDecode, "u", 1'b0, 3'd3, {8'h00, "Man"}, 1'b0));
        directed.push_back(vec(DirDecode, CharPad, 1'b1, 3'd0, 32'h0, 1'b1));
        // Padding mid-message flushes the partial group; later characters are ignored.
        directed.push_back(vec(DirDecode, "Q", 1'b0, 3'd0, 32'h0, 1'b0));
        directed.push_back(vec(DirDecode, "Q", 1'b0, 3'd0, 32'h0, 1'b0));
        directed.push_back(vec(DirDecode, CharPad, 1'b0, 3'd1, {24'h000000, "A"}, 1'b0));
        directed.push_back(vec(DirDecode, CharPad, 1'b1, 3'd0, 32'h0, 1'b1));
        // A character outside the alphabet stops decoding the same way.
        directed.push_back(vec(DirDecode, "+", 1'b0, 3'd0, 32'h0, 1'b0));
        directed.push_back(vec(DirDecode, "/", 1'b0, 3'd0, 32'h0, 1'b0));
        directed.push_back(vec(DirDecode, "9", 1'b0, 3'd0, 32'h0, 1'b0));
        directed.push_back(vec(DirDecode, 8'hff, 1'b0, 3'd0, 32'h0, 1'b0));
        directed.push_back(vec(DirDecode, "x", 1'b1, 3'd0, 32'h0, 1'b1));
        // A single held sextet flushes nothing.
        directed.push_back(vec(DirDecode, "z", 1'b1, 3'd0, 32'h0, 1'b1));
        // Switch to encode with two sextets held: the group is read as bytes.
        directed.push_back(vec(DirDecode, "A", 1'b0, 3'd0, 32'h0, 1'b0));
        directed.push_back(vec(DirDecode, "B", 1'b0, 3'd0, 32'h0, 1'b0));
        directed.push_back(vec(DirEncode, 8'h12, 1'b1, 3'd0, 32'h0, 1'b0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_direction(DirEncode);

        foreach (directed[i])
        begin
            v = directed[i];
            if (v.dir != model_dir)
                write_direction(v.dir);
            it.in_byte = v.in_byte;
            it.msg_last = v.msg_last;
            send_request(it);
            if (v.end_marker)
            begin
                r = '0;
                r.run_last = 1'b1;
                r.msg_end = 1'b1;
                pending_results.push_back(r);
            end
            else if (v.n_typed != 0)
            begin
                for (int k = 0; k < v.n_typed; k++)
                begin
                    r.out_byte = v.typed_text[(v.n_typed - 1 - k) * 8 +: 8];
                    r.has_data = 1'b1;
                    r.run_last = (k == v.n_typed - 1);
                    r.msg_end = v.msg_last && r.run_last;
                    pending_results.push_back(r);
                end
            end
            else
            begin
                queue_predicted();
            end
        end

        // Random messages. Decode messages are mostly well formed: alphabet characters with
        // optional padding at the end, lengths often whole groups. Some carry noise bytes,
        // and now and then the direction flips in the middle of a message.
        sent = 0;
        while (sent < RandomItems)
        begin
            tx_calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 3) == 0)
                write_direction(1'($urandom_range(0, 1)));
            else if ($urandom_range(0, 15) == 0)
                settle();
            if ($urandom_range(0, 1) == 0)
                msg_len = 4 * $urandom_range(1, 3);
            else
                msg_len = $urandom_range(1, 12);
            n_pad = $urandom_range(0, 2);
            noisy = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < msg_len; k++)
            begin
                if (k > 0 && $urandom_range(0, 39) == 0)
                    write_direction(!model_dir);
                if (model_dir == DirEncode)
                    b = 8'($urandom_range(0, 255));
                else if (noisy && $urandom_range(0, 2) == 0)
                    b = 8'($urandom_range(0, 255));
                else if (k + n_pad >= msg_len)
                    b = CharPad;
                else
                    b = sextet_char(6'($urandom_range(0, 63)));
                it.in_byte = b;
                it.msg_last = (k == msg_len - 1);
                send_request(it);
                queue_predicted();
                sent++;
            end
        end

        settle();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
